@@ hw/rtl/rth_pkg.sv @@
// Shared types, constants and the divider step for the RGB to HSV pixel converter.
package rth_pkg;

  localparam int FracBitsDef = 6;   // default fraction bits of hue and saturation
  localparam int ChanW       = 8;   // width of one color sample
  localparam int HueIntW     = 9;   // integer bits of hue (below 360)
  localparam int DivW        = 9;   // divisor and remainder width (2 * 8-bit value)
  localparam int HueW        = 15;
  localparam int SatW        = 14;
  localparam int TdataInW    = 24;
  localparam int TdataOutW   = 40;

  // which channel is largest, and for red the sign of green minus blue
  typedef enum logic [1:0] {
    SecRedPos = 2'd0,
    SecRedNeg = 2'd1,
    SecGreen  = 2'd2,
    SecBlue   = 2'd3
  } sector_e;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DivW-1:0] dvs;
  } rth_lane_t;

  typedef struct packed {
    logic            qbit;
    logic [DivW-1:0] rem;
  } rth_step_t;

  // one restoring division step: bring in the next dividend bit, trial subtract
  function automatic rth_step_t rth_div_step(logic [DivW-1:0] rem, logic nbit,
                                             logic [DivW-1:0] dvs);
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    rth_step_t     res;
    trial    = {rem, nbit};
    diff     = trial - {1'b0, dvs};
    res.qbit = (trial >= {1'b0, dvs});
    res.rem  = res.qbit ? diff[DivW-1:0] : trial[DivW-1:0];
    return res;
  endfunction

endpackage

@@ hw/rtl/rth_div_stage.sv @@
// One pipeline stage of the hue and saturation dividers: one quotient bit each.
module rth_div_stage import rth_pkg::*; #(
  parameter int QW = HueIntW + FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ChanW-1:0] val_i,
  input  rth_lane_t        hue_lane_i,
  input  logic [QW-1:0]    hue_low_i,
  input  rth_lane_t        sat_lane_i,
  input  logic [QW-1:0]    sat_low_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [ChanW-1:0] val_o,
  output rth_lane_t        hue_lane_o,
  output logic [QW-1:0]    hue_low_o,
  output rth_lane_t        sat_lane_o,
  output logic [QW-1:0]    sat_low_o
);

  logic             valid_q, valid_d;
  logic [ChanW-1:0] val_q;
  rth_lane_t        hue_lane_q, hue_lane_d, sat_lane_q, sat_lane_d;
  logic [QW-1:0]    hue_low_q, hue_low_d, sat_low_q, sat_low_d;
  rth_step_t        hue_step, sat_step;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    hue_step       = rth_div_step(hue_lane_i.rem, hue_low_i[QW-1], hue_lane_i.dvs);
    sat_step       = rth_div_step(sat_lane_i.rem, sat_low_i[QW-1], sat_lane_i.dvs);
    hue_lane_d.rem = hue_step.rem;
    hue_lane_d.dvs = hue_lane_i.dvs;
    sat_lane_d.rem = sat_step.rem;
    sat_lane_d.dvs = sat_lane_i.dvs;
    // shift out the used dividend bit, shift in the quotient bit
    hue_low_d      = {hue_low_i[QW-2:0], hue_step.qbit};
    sat_low_d      = {sat_low_i[QW-2:0], sat_step.qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      val_q      <= val_i;
      hue_lane_q <= hue_lane_d;
      hue_low_q  <= hue_low_d;
      sat_lane_q <= sat_lane_d;
      sat_low_q  <= sat_low_d;
    end
  end

  assign valid_o    = valid_q;
  assign val_o      = val_q;
  assign hue_lane_o = hue_lane_q;
  assign hue_low_o  = hue_low_q;
  assign sat_lane_o = sat_lane_q;
  assign sat_low_o  = sat_low_q;

endmodule

@@ hw/rtl/rgb_to_hsv_pixel.sv @@
// Top level of the RGB to HSV pixel converter: front stages and divider pipeline.
//
// Usage: one 8-bit RGB pixel enters per item on the slave stream and one HSV
// item leaves on the master stream, in the same order. No state is kept
// between pixels.
// Input tdata holds red, green, blue from the lowest byte up. Output tdata
// holds hue (1/2^FracBits degree), saturation (0..255 in 1/2^FracBits) and
// brightness (largest channel), from the lowest bit up.
// Steps: the first stage finds the largest and smallest channel, the second
// forms the numerators, then each divider stage adds one quotient bit to
// both restoring dividers, which run side by side.
// Throughput: one item per cycle unless stalled; each stage has its own valid bit.
// Stall: when the receiver drops m_axis_tready, the output item holds and
// items behind it keep moving into empty stages, so s_axis_tready falls only
// once every stage is full. Nothing is dropped or repeated.
// Reset: all valid bits clear; the pipeline is empty and ready at once.
module rgb_to_hsv_pixel import rth_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TdataInW-1:0]  s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataOutW-1:0] m_axis_tdata    // hue [14:0], saturation [28:15],
                                               // brightness [36:29], zero fill
);

  localparam int QW      = HueIntW + FracBits;  // quotient bits per divider
  localparam int NW      = QW + DivW;           // dividend width
  localparam int HueLim  = 360 * (2 ** FracBits);
  localparam int SatLim  = 255 * (2 ** FracBits);
  localparam int BaseW   = 17;                  // 360 * 255 fits
  localparam int PadW    = TdataOutW - HueW - SatW - ChanW;

  // ---------------- stage 1: max, min, sector ----------------
  logic [ChanW-1:0]   red, green, blue;
  logic [ChanW-1:0]   mx_d, mn_d, mx_q, delta_q;
  logic signed [ChanW:0] diff_d, diff_q;
  sector_e            sec_d, sec_q;
  logic               v1_q, rdy1;

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];

  always_comb begin
    priority if (red >= green && red >= blue) begin
      mx_d   = red;
      sec_d  = (green >= blue) ? SecRedPos : SecRedNeg;
      diff_d = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      mx_d   = green;
      sec_d  = SecGreen;
      diff_d = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      mx_d   = blue;
      sec_d  = SecBlue;
      diff_d = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mn_d = red;
    if (green < mn_d) mn_d = green;
    if (blue < mn_d) mn_d = blue;
  end

  // ---------------- stage 2: numerators and divisors ----------------
  logic [QW+1:0]      rdy;
  logic               vld    [QW+1];
  logic [ChanW-1:0]   val    [QW+1];
  rth_lane_t          h_lane [QW+1];
  rth_lane_t          s_lane [QW+1];
  logic [QW-1:0]      h_low  [QW+1];
  logic [QW-1:0]      s_low  [QW+1];

  logic               vld0_q;
  logic [ChanW-1:0]   val0_q;
  rth_lane_t          h_lane0_q, s_lane0_q;
  logic [QW-1:0]      h_low0_q, s_low0_q;

  logic [BaseW-1:0]   base;
  logic signed [BaseW:0] hterm, hnum;
  logic [15:0]        snum;
  logic [NW-1:0]      hdvd, sdvd;
  logic [DivW-1:0]    hdvs, sdvs;

  assign rdy1          = !v1_q || rdy[0];
  assign s_axis_tready = rdy1;
  assign rdy[0]        = !vld[0] || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy1) begin
      mx_q    <= mx_d;
      delta_q <= mx_d - mn_d;
      diff_q  <= diff_d;
      sec_q   <= sec_d;
    end
  end

  always_comb begin
    unique case (sec_q)
      SecRedPos: base = '0;
      SecRedNeg: base = BaseW'(delta_q) * BaseW'(360);
      SecGreen:  base = BaseW'(delta_q) * BaseW'(120);
      SecBlue:   base = BaseW'(delta_q) * BaseW'(240);
      default:   base = '0;
    endcase
    hterm = (BaseW+1)'(diff_q) * $signed((BaseW+1)'(60));
    hnum  = $signed({1'b0, base}) + hterm;
    // round to nearest: (2*num + den) / (2*den)
    hdvd  = (NW'(hnum[BaseW-1:0]) << (FracBits + 1)) + NW'(delta_q);
    hdvs  = (delta_q == '0) ? DivW'(1) : {delta_q, 1'b0};
    snum  = 16'(delta_q) * 16'd255;
    sdvd  = (NW'(snum) << (FracBits + 1)) + NW'(mx_q);
    sdvs  = (mx_q == '0) ? DivW'(1) : {mx_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (rdy[0]) begin
      vld0_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy[0]) begin
      val0_q        <= mx_q;
      h_lane0_q.rem <= hdvd[NW-1:QW];
      h_lane0_q.dvs <= hdvs;
      h_low0_q      <= hdvd[QW-1:0];
      s_lane0_q.rem <= sdvd[NW-1:QW];
      s_lane0_q.dvs <= sdvs;
      s_low0_q      <= sdvd[QW-1:0];
    end
  end

  assign vld[0]    = vld0_q;
  assign val[0]    = val0_q;
  assign h_lane[0] = h_lane0_q;
  assign h_low[0]  = h_low0_q;
  assign s_lane[0] = s_lane0_q;
  assign s_low[0]  = s_low0_q;

  // ---------------- divider pipeline: one quotient bit per stage ----------------
  assign rdy[QW+1] = m_axis_tready;

  for (genvar k = 1; k <= QW; k++) begin : g_div
    rth_div_stage #(
      .QW (QW)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (vld[k-1]),
      .ready_o    (rdy[k]),
      .val_i      (val[k-1]),
      .hue_lane_i (h_lane[k-1]),
      .hue_low_i  (h_low[k-1]),
      .sat_lane_i (s_lane[k-1]),
      .sat_low_i  (s_low[k-1]),
      .valid_o    (vld[k]),
      .ready_i    (rdy[k+1]),
      .val_o      (val[k]),
      .hue_lane_o (h_lane[k]),
      .hue_low_o  (h_low[k]),
      .sat_lane_o (s_lane[k]),
      .sat_low_o  (s_low[k])
    );
  end

  assign m_axis_tvalid = vld[QW];
  assign m_axis_tdata  = {PadW'(0), val[QW], SatW'(s_low[QW]), HueW'(h_low[QW])};

  // ---------------- assertions ----------------
  // a grey pixel has zero saturation and zero hue, and only a grey pixel has
  // zero saturation
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && s_low[QW] == '0 |-> h_low[QW] == '0)
    else $error("zero saturation with nonzero hue");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> h_low[QW] < QW'(HueLim))
    else $error("hue quotient at or above 360 degrees");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> s_low[QW] <= QW'(SatLim))
    else $error("saturation quotient above full scale");

  // the quotient must fit: the starting remainder is below the divisor
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[0] |-> h_lane[0].rem < h_lane[0].dvs && s_lane[0].rem < s_lane[0].dvs)
    else $error("divider start remainder not below divisor");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy[0] |=> v1_q && $stable(mx_q) && $stable(delta_q))
    else $error("front stage item lost while stalled");

endmodule
